// ===== rtl/core/bgr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, codes and fp helpers for the bf16 row-tile GEMM block.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int LANES = 4;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16 = 16'h7FC0;
  localparam logic [31:0] CLAMP_LOW_RST  = 32'hFF80_0000;
  localparam logic [31:0] CLAMP_HIGH_RST = 32'h7F80_0000;
  localparam int GUARD = 38;

  // register indexes on the config port
  localparam logic REG_CLAMP_LOW  = 1'b0;
  localparam logic REG_CLAMP_HIGH = 1'b1;

  typedef struct packed {
    logic [15:0]                  activation;
    logic [LANES-1:0][15:0]       weight;
    logic [LANES-1:0][31:0]       bias;
    logic                         first_step;
    logic                         last_step;
  } bgr_item_t;

  typedef logic [LANES-1:0][15:0] bgr_result_t;

  typedef struct packed {
    logic dec;
    logic aln;
    logic add;
    logic rnd;
  } bgr_lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_ALN,
    ST_ADD,
    ST_RND,
    ST_EMIT
  } bgr_state_t;

  // index of the highest set bit, 0 for a zero word
  function automatic logic [5:0] msb64(input logic [63:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  // round s * m * 2^e to fp32, nearest-even, subnormals kept
  function automatic logic [31:0] round_pack(input logic s, input logic [63:0] m,
                                             input logic signed [11:0] e);
    logic [5:0]         p;
    logic signed [11:0] sh;
    logic signed [11:0] lim;
    logic signed [11:0] q;
    logic signed [11:0] ex;
    logic [63:0]        mask;
    logic [63:0]        rem;
    logic [63:0]        half;
    logic [24:0]        sig;
    logic [31:0]        res;
    p    = msb64(m);
    sh   = $signed({6'b0, p}) - 12'sd23;
    lim  = -12'sd149 - e;
    if (lim > sh) sh = lim;
    res  = '0;
    sig  = '0;
    mask = '0;
    rem  = '0;
    half = '0;
    q    = '0;
    ex   = '0;
    if (sh >= 12'sd64) begin
      res = {s, 31'b0};
    end else begin
      if (sh <= 12'sd0) begin
        sig = 25'(m << 6'(-sh));
      end else begin
        mask = (64'd1 << 6'(sh)) - 64'd1;
        rem  = m & mask;
        half = 64'd1 << 6'(sh - 12'sd1);
        sig  = 25'(m >> 6'(sh));
        if (rem > half || (rem == half && sig[0])) sig = sig + 25'd1;
      end
      q = e + sh;
      if (sig[24]) begin
        sig = sig >> 1;
        q   = q + 12'sd1;
      end
      if (sig[23]) begin
        ex = q + 12'sd150;
        if (ex >= 12'sd255) res = {s, 8'hFF, 23'b0};
        else                res = {s, ex[7:0], sig[22:0]};
      end else begin
        res = {s, 8'b0, sig[22:0]};
      end
    end
    return res;
  endfunction

  function automatic logic is_nan32(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != '0);
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] x);
    return x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  // maximumNumber / minimumNumber, NaN side ignored
  function automatic logic [31:0] pick(input logic [31:0] x, input logic [31:0] y,
                                       input logic want_max);
    logic xn;
    logic yn;
    logic [31:0] res;
    xn = is_nan32(x);
    yn = is_nan32(y);
    if (xn && yn)    res = QNAN32;
    else if (xn)     res = y;
    else if (yn)     res = x;
    else if (want_max) res = (order_key(x) >= order_key(y)) ? x : y;
    else             res = (order_key(x) <= order_key(y)) ? x : y;
    return res;
  endfunction

  function automatic logic [15:0] narrow_bf16(input logic [31:0] x);
    logic [15:0] hi;
    logic [15:0] rem;
    hi  = x[31:16];
    rem = x[15:0];
    if (is_nan32(x)) begin
      hi = QNAN16;
    end else if (rem > 16'h8000 || (rem == 16'h8000 && hi[0])) begin
      hi = hi + 16'd1;
    end
    return hi;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bgr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_front
// Input side: takes transactions into a two-entry queue toward the datapath.
// ----------------------------------------------------------------------------
module bgr_front
  import bgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  bgr_item_t item_in,
  output logic      q_valid,
  output bgr_item_t q_item,
  input  logic      q_pop
);

  bgr_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= item_in;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bgr_fma_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_fma_lane
// One lane: bf16 x bf16 + fp32 fused multiply-add over decode, align, add
// and round steps, holding the fp32 accumulator.
// ----------------------------------------------------------------------------
module bgr_fma_lane
  import bgr_pkg::*;
(
  input  logic          clk,
  input  bgr_lane_ctl_t ctl,
  input  logic [15:0]   activation,
  input  logic [15:0]   weight,
  input  logic [31:0]   bias,
  input  logic          first_step,
  output logic [31:0]   acc
);

  logic [31:0] acc_r;

  // decode step
  logic [31:0]        c;
  logic [7:0]         ae, we, ce;
  logic [6:0]         af, wf;
  logic [22:0]        cf;
  logic               sp, sc;
  logic               a_zero, w_zero, a_inf, w_inf, c_zero, c_inf;
  logic               spec;
  logic [31:0]        sval;
  logic [7:0]         ma, mw;
  logic [15:0]        mp;
  logic signed [11:0] exp_a, exp_w, ep_raw, ec;
  logic [5:0]         kp, kc;
  logic [23:0]        mc;

  logic               d0_spec_r, d0_czero_r, d0_sp_r, d0_sc_r;
  logic [31:0]        d0_sval_r;
  logic [15:0]        d0_mp_r;
  logic signed [11:0] d0_ep_raw_r, d0_ep_r, d0_ec_r;
  logic [23:0]        d0_mpn_r, d0_mcn_r;

  always_comb begin
    c      = first_step ? bias : acc_r;
    ae     = activation[14:7];
    af     = activation[6:0];
    we     = weight[14:7];
    wf     = weight[6:0];
    ce     = c[30:23];
    cf     = c[22:0];
    sc     = c[31];
    sp     = activation[15] ^ weight[15];
    a_zero = (ae == 8'd0) && (af == 7'd0);
    w_zero = (we == 8'd0) && (wf == 7'd0);
    a_inf  = (ae == 8'hFF);
    w_inf  = (we == 8'hFF);
    c_zero = (ce == 8'd0) && (cf == 23'd0);
    c_inf  = (ce == 8'hFF);

    spec = 1'b1;
    sval = c;
    if ((a_inf && af != '0) || (w_inf && wf != '0) || (c_inf && cf != '0)) begin
      sval = QNAN32;
    end else if ((a_inf && w_zero) || (w_inf && a_zero)) begin
      sval = QNAN32;
    end else if (a_inf || w_inf) begin
      sval = (c_inf && sc != sp) ? QNAN32 : {sp, 8'hFF, 23'b0};
    end else if (c_inf) begin
      sval = c;
    end else if (a_zero || w_zero) begin
      sval = c_zero ? {sc & sp, 31'b0} : c;
    end else begin
      spec = 1'b0;
    end

    ma     = {ae != 8'd0, af};
    mw     = {we != 8'd0, wf};
    mp     = ma * mw;
    exp_a  = (ae != 8'd0) ? ($signed({4'b0, ae}) - 12'sd134) : -12'sd133;
    exp_w  = (we != 8'd0) ? ($signed({4'b0, we}) - 12'sd134) : -12'sd133;
    ep_raw = exp_a + exp_w;
    mc     = {ce != 8'd0, cf};
    ec     = (ce != 8'd0) ? ($signed({4'b0, ce}) - 12'sd150) : -12'sd149;
    kp     = 6'd23 - msb64({48'b0, mp});
    kc     = 6'd23 - msb64({40'b0, mc});
  end

  always_ff @(posedge clk) begin
    if (ctl.dec) begin
      d0_spec_r   <= spec;
      d0_sval_r   <= sval;
      d0_czero_r  <= c_zero;
      d0_sp_r     <= sp;
      d0_sc_r     <= sc;
      d0_mp_r     <= mp;
      d0_ep_raw_r <= ep_raw;
      d0_mpn_r    <= 24'(mp) << kp;
      d0_ep_r     <= ep_raw - $signed({6'b0, kp});
      d0_mcn_r    <= mc << kc;
      d0_ec_r     <= ec - $signed({6'b0, kc});
    end
  end

  // align step
  logic               p_big;
  logic [23:0]        big_m, small_m;
  logic signed [11:0] big_e, small_e, exp_diff;
  logic               big_s, small_s;
  logic [4:0]         rsh;
  logic [63:0]        ms;

  logic               a1_spec_r, a1_czero_r, a1_bigs_r, a1_smalls_r;
  logic [31:0]        a1_sval_r;
  logic [63:0]        a1_mb_r, a1_ms_r;
  logic signed [11:0] a1_e_r;

  always_comb begin
    p_big = (d0_ep_r > d0_ec_r) || (d0_ep_r == d0_ec_r && d0_mpn_r >= d0_mcn_r);
    if (p_big) begin
      big_m = d0_mpn_r; big_e = d0_ep_r; big_s = d0_sp_r;
      small_m = d0_mcn_r; small_e = d0_ec_r; small_s = d0_sc_r;
    end else begin
      big_m = d0_mcn_r; big_e = d0_ec_r; big_s = d0_sc_r;
      small_m = d0_mpn_r; small_e = d0_ep_r; small_s = d0_sp_r;
    end
    exp_diff = big_e - small_e;
    rsh      = 5'(exp_diff - 12'sd38);
    if (exp_diff <= 12'sd38) begin
      ms = {40'b0, small_m} << 6'(12'sd38 - exp_diff);
    end else if (exp_diff >= 12'sd62) begin
      ms = 64'd1;   // far below: sticky only
    end else begin
      ms = ({40'b0, small_m} >> rsh)
         | {63'b0, |(small_m & ((24'd1 << rsh) - 24'd1))};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.aln) begin
      a1_spec_r  <= d0_spec_r;
      a1_sval_r  <= d0_sval_r;
      a1_czero_r <= d0_czero_r;
      if (d0_czero_r) begin
        // zero accumulator: the exact product is rounded directly
        a1_mb_r     <= '0;
        a1_ms_r     <= {48'b0, d0_mp_r};
        a1_e_r      <= d0_ep_raw_r;
        a1_bigs_r   <= d0_sp_r;
        a1_smalls_r <= d0_sp_r;
      end else begin
        a1_mb_r     <= {big_m, 40'b0} >> 2;
        a1_ms_r     <= ms;
        a1_e_r      <= big_e - 12'(GUARD);
        a1_bigs_r   <= big_s;
        a1_smalls_r <= small_s;
      end
    end
  end

  // add step
  logic [63:0] sum;
  logic        rs;

  logic               s2_spec_r, s2_zero_r, s2_rs_r;
  logic [31:0]        s2_sval_r;
  logic [63:0]        s2_sum_r;
  logic signed [11:0] s2_e_r;

  always_comb begin
    if (a1_czero_r) begin
      sum = a1_ms_r;
      rs  = a1_bigs_r;
    end else if (a1_bigs_r == a1_smalls_r) begin
      sum = a1_mb_r + a1_ms_r;
      rs  = a1_bigs_r;
    end else if (a1_mb_r >= a1_ms_r) begin
      sum = a1_mb_r - a1_ms_r;
      rs  = a1_bigs_r;
    end else begin
      sum = a1_ms_r - a1_mb_r;
      rs  = a1_smalls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add) begin
      s2_spec_r <= a1_spec_r;
      s2_sval_r <= a1_sval_r;
      s2_sum_r  <= sum;
      s2_rs_r   <= rs;
      s2_e_r    <= a1_e_r;
      s2_zero_r <= (sum == 64'd0);
    end
  end

  // round step writes the accumulator
  always_ff @(posedge clk) begin
    if (ctl.rnd) begin
      if (s2_spec_r)      acc_r <= s2_sval_r;
      else if (s2_zero_r) acc_r <= 32'd0;
      else                acc_r <= round_pack(s2_rs_r, s2_sum_r, s2_e_r);
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== rtl/core/bgr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_back
// Datapath side: sequences the lanes through decode, align, add and round
// per item, clamps and narrows on a last step, and queues results.
// ----------------------------------------------------------------------------
module bgr_back
  import bgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  bgr_item_t   q_item,
  output logic        q_pop,
  input  logic [31:0] clamp_low,
  input  logic [31:0] clamp_high,
  output logic        res_push,
  output logic        empty,
  input  logic        pop,
  output bgr_result_t res
);

  bgr_state_t    st_r, st_nxt;
  bgr_item_t     item_r;
  bgr_lane_ctl_t ctl;
  logic          room;

  logic [LANES-1:0][31:0] acc;
  bgr_result_t            narrowed;

  bgr_result_t oq_mem_r [2];
  logic        oq_wr_r, oq_rd_r;
  logic [1:0]  oq_cnt_r;
  logic        oq_pop;

  assign room = (oq_cnt_r != 2'd2);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: st_nxt = q_valid ? ST_DEC : ST_IDLE;
      ST_DEC:  st_nxt = ST_ALN;
      ST_ALN:  st_nxt = ST_ADD;
      ST_ADD:  st_nxt = ST_RND;
      ST_RND: begin
        if (item_r.last_step) st_nxt = ST_EMIT;
        else                  st_nxt = q_valid ? ST_DEC : ST_IDLE;
      end
      ST_EMIT: begin
        if (room) st_nxt = q_valid ? ST_DEC : ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    res_push = 1'b0;
    ctl      = '0;
    case (st_r)
      ST_IDLE: q_pop = q_valid;
      ST_DEC:  ctl.dec = 1'b1;
      ST_ALN:  ctl.aln = 1'b1;
      ST_ADD:  ctl.add = 1'b1;
      ST_RND: begin
        ctl.rnd = 1'b1;
        q_pop   = q_valid && !item_r.last_step;
      end
      ST_EMIT: begin
        res_push = room;
        q_pop    = q_valid && room;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bgr_fma_lane u_lane (
      .clk        (clk),
      .ctl        (ctl),
      .activation (item_r.activation),
      .weight     (item_r.weight[i]),
      .bias       (item_r.bias[i]),
      .first_step (item_r.first_step),
      .acc        (acc[i])
    );
    assign narrowed[i] = narrow_bf16(pick(pick(acc[i], clamp_low, 1'b1), clamp_high, 1'b0));
  end

  // result queue
  assign empty  = (oq_cnt_r == 2'd0);
  assign oq_pop = pop && !empty;
  assign res    = oq_mem_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= oq_wr_r ^ res_push;
      oq_rd_r  <= oq_rd_r ^ oq_pop;
      oq_cnt_r <= oq_cnt_r + 2'(res_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) oq_mem_r[oq_wr_r] <= narrowed;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bf16_gemm_row_clamp_narrow.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf16_gemm_row_clamp_narrow
// One row by four columns of a bf16 matrix product with fp32 accumulation,
// clamp against programmable bounds and bf16 narrowing.
//
//   channel | ports                     | handshake
//   input   | in_*                      | in_push / in_full
//   result  | out_out_0..3              | out_pop / out_empty
//   config  | cfg_p*                    | APB write, pready tied high
//
// Each item passes through the decode, align, add and round steps of the
// lane datapath; the accumulator feedback through these steps sets the rate.
// A last-step item adds an emit state for clamp and narrowing into the result
// queue. Two-entry queues on both sides let input and output stall apart.
// Reset is synchronous, active low; accumulators are valid after a first step.
// ----------------------------------------------------------------------------
module bf16_gemm_row_clamp_narrow
  import bgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_activation,
  input  logic [15:0] in_weight_0,
  input  logic [15:0] in_weight_1,
  input  logic [15:0] in_weight_2,
  input  logic [15:0] in_weight_3,
  input  logic [31:0] in_bias_0,
  input  logic [31:0] in_bias_1,
  input  logic [31:0] in_bias_2,
  input  logic [31:0] in_bias_3,
  input  logic        in_first_step,
  input  logic        in_last_step,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_out_0,
  output logic [15:0] out_out_1,
  output logic [15:0] out_out_2,
  output logic [15:0] out_out_3,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] clamp_low_r, clamp_high_r;
  logic        cfg_wr;
  bgr_item_t   item_in, q_item;
  logic        q_valid, q_pop, res_push;
  bgr_result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_low_r  <= CLAMP_LOW_RST;
      clamp_high_r <= CLAMP_HIGH_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_CLAMP_LOW) clamp_low_r  <= cfg_pwdata;
      else                               clamp_high_r <= cfg_pwdata;
    end
  end

  always_comb begin
    if (cfg_paddr[1:0] != 2'b00)            cfg_prdata = '0;
    else if (cfg_paddr[2] == REG_CLAMP_LOW) cfg_prdata = clamp_low_r;
    else                                    cfg_prdata = clamp_high_r;
  end

  always_comb begin
    item_in.activation = in_activation;
    item_in.weight     = {in_weight_3, in_weight_2, in_weight_1, in_weight_0};
    item_in.bias       = {in_bias_3, in_bias_2, in_bias_1, in_bias_0};
    item_in.first_step = in_first_step;
    item_in.last_step  = in_last_step;
  end

  bgr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .item_in (item_in),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  bgr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .clamp_low  (clamp_low_r),
    .clamp_high (clamp_high_r),
    .res_push   (res_push),
    .empty      (out_empty),
    .pop        (out_pop),
    .res        (res)
  );

  assign out_out_0 = res[0];
  assign out_out_1 = res[1];
  assign out_out_2 = res[2];
  assign out_out_3 = res[3];

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("datapath took an item from an empty input queue");

  a_reset_queues: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(res_push))
    else $error("result appeared without a datapath push");

endmodule
`default_nettype wire

// ===== dv/bf16_gemm_row_clamp_narrow_tb.sv =====
// ----------------------------------------------------------------------------
// bf16_gemm_row_clamp_narrow_tb
// Self-checking bench for the bf16 row-tile GEMM block. Dot-product step
// transactions go in through the push/full queue port. A bit-exact fp32
// fused multiply-add, clamp and bf16 narrowing predictor builds the expected
// tiles, and every popped tile is checked lane by lane against them. Clamp
// bounds are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module bf16_gemm_row_clamp_narrow_tb;
  import bgr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [15:0] in_activation;
  logic [15:0] in_weight_0, in_weight_1, in_weight_2, in_weight_3;
  logic [31:0] in_bias_0, in_bias_1, in_bias_2, in_bias_3;
  logic        in_first_step, in_last_step;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_out_0, out_out_1, out_out_2, out_out_3;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bf16_gemm_row_clamp_narrow DUT (.*);

  // predictor state
  logic [31:0] lane_acc [LANES];
  logic [31:0] clamp_lo, clamp_hi;
  bgr_result_t tile_q [$];

  int mismatches;
  int idle_cycles;
  int burst_left;
  bit long_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- fp model
  function automatic logic [31:0] fp32_round(bit s, bit [63:0] m, int e);
    int p, sh, q, ex;
    bit [63:0] rem, half, sig;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh >= 64) return {s, 31'b0};
    if (sh <= 0) begin
      sig = m << (-sh);
    end else begin
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      sig  = m >> sh;
      if (rem > half || (rem == half && sig[0])) sig++;
    end
    q = e + sh;
    if (sig >= 64'h100_0000) begin
      sig = sig >> 1;
      q++;
    end
    if (sig >= 64'h80_0000) begin
      ex = q + 150;
      if (ex >= 255) return {s, 8'hFF, 23'b0};
      return {s, 8'(ex), sig[22:0]};
    end
    return {s, 8'b0, sig[22:0]};
  endfunction

  function automatic logic [31:0] fma_step(logic [31:0] acc, logic [15:0] a,
                                           logic [15:0] w);
    bit sp, big_s, small_s, rs;
    bit a_zero, w_zero, a_inf, w_inf, c_zero, c_inf;
    bit [63:0] mp, mc, big_m, small_m, mb, ms, total;
    int ep, ec, big_e, small_e, d, r;
    sp     = a[15] ^ w[15];
    a_zero = a[14:0] == 0;
    w_zero = w[14:0] == 0;
    a_inf  = a[14:7] == 8'hFF;
    w_inf  = w[14:7] == 8'hFF;
    c_zero = acc[30:0] == 0;
    c_inf  = acc[30:23] == 8'hFF;
    if ((a_inf && a[6:0] != 0) || (w_inf && w[6:0] != 0) ||
        (c_inf && acc[22:0] != 0)) return FP_QNAN;
    if ((a_inf && w_zero) || (w_inf && a_zero)) return FP_QNAN;
    if (a_inf || w_inf) begin
      if (c_inf && acc[31] != sp) return FP_QNAN;
      return {sp, 8'hFF, 23'b0};
    end
    if (c_inf) return acc;
    if (a_zero || w_zero) begin
      if (c_zero) return {acc[31] & sp, 31'b0};
      return acc;
    end
    mp = (a[14:7] != 0 ? {1'b1, a[6:0]} : {1'b0, a[6:0]}) *
         (w[14:7] != 0 ? {1'b1, w[6:0]} : {1'b0, w[6:0]});
    ep = (a[14:7] != 0 ? int'(a[14:7]) - 134 : -133) +
         (w[14:7] != 0 ? int'(w[14:7]) - 134 : -133);
    if (c_zero) return fp32_round(sp, mp, ep);
    mc = acc[30:23] != 0 ? {1'b1, acc[22:0]} : {1'b0, acc[22:0]};
    ec = acc[30:23] != 0 ? int'(acc[30:23]) - 150 : -149;
    while (mp < 64'h80_0000) begin mp <<= 1; ep--; end
    while (mc < 64'h80_0000) begin mc <<= 1; ec--; end
    if (ep > ec || (ep == ec && mp >= mc)) begin
      big_m = mp; big_e = ep; big_s = sp; small_m = mc; small_e = ec; small_s = acc[31];
    end else begin
      big_m = mc; big_e = ec; big_s = acc[31]; small_m = mp; small_e = ep; small_s = sp;
    end
    d  = big_e - small_e;
    mb = big_m << 38;
    if (d <= 38) begin
      ms = small_m << (38 - d);
    end else if (d - 38 >= 64) begin
      ms = 1;
    end else begin
      r  = d - 38;
      ms = (small_m >> r) | ((small_m & ((64'd1 << r) - 64'd1)) != 0);
    end
    if (big_s == small_s) begin
      total = mb + ms; rs = big_s;
    end else if (mb >= ms) begin
      total = mb - ms; rs = big_s;
    end else begin
      total = ms - mb; rs = small_s;
    end
    if (total == 0) return 32'h0;
    return fp32_round(rs, total, big_e - 38);
  endfunction

  function automatic bit fp_is_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic logic [31:0] sort_key(logic [31:0] x);
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  // IEEE maximumNumber / minimumNumber
  function automatic logic [31:0] bound_pick(logic [31:0] x, logic [31:0] y, bit take_max);
    if (fp_is_nan(x) && fp_is_nan(y)) return FP_QNAN;
    if (fp_is_nan(x)) return y;
    if (fp_is_nan(y)) return x;
    if (take_max) return sort_key(x) >= sort_key(y) ? x : y;
    return sort_key(x) <= sort_key(y) ? x : y;
  endfunction

  function automatic logic [15:0] to_bf16(logic [31:0] x);
    logic [15:0] hi;
    if (fp_is_nan(x)) return 16'h7FC0;
    hi = x[31:16];
    if (x[15:0] > 16'h8000 || (x[15:0] == 16'h8000 && hi[0])) hi++;
    return hi;
  endfunction

  function automatic void predict_step(bgr_item_t it);
    bgr_result_t tile;
    for (int i = 0; i < LANES; i++) begin
      if (it.first_step) lane_acc[i] = it.bias[i];
      lane_acc[i] = fma_step(lane_acc[i], it.activation, it.weight[i]);
      tile[i] = to_bf16(bound_pick(bound_pick(lane_acc[i], clamp_lo, 1'b1), clamp_hi, 1'b0));
    end
    if (it.last_step) tile_q.push_back(tile);
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [15:0] rand_bf16();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 15'h0};
      1: return {1'($urandom), 8'hFF, 7'h0};
      2: return {1'($urandom), 8'hFF, 7'($urandom_range(1, 127))};
      3: return {1'($urandom), 8'h00, 7'($urandom)};
      4: return 16'($urandom);
      default: return {1'($urandom), 8'($urandom_range(110, 145)), 7'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_fp32();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 31'h0};
      1: return {1'($urandom), 8'hFF, 23'h0};
      2: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      3: return {1'($urandom), 8'h00, 23'($urandom)};
      4: return $urandom;
      5: return {1'($urandom), 8'hFE, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endcase
  endfunction

  function automatic bgr_item_t rand_item(bit first, bit last);
    bgr_item_t it;
    it.activation = rand_bf16();
    for (int i = 0; i < LANES; i++) begin
      it.weight[i] = rand_bf16();
      it.bias[i]   = rand_fp32();
    end
    it.first_step = first;
    it.last_step  = last;
    return it;
  endfunction

  function automatic bgr_item_t make_item(logic [15:0] a, logic [15:0] w, logic [31:0] b,
                                          bit first, bit last);
    bgr_item_t it;
    it.activation = a;
    it.weight     = {LANES{w}};
    it.bias       = {LANES{b}};
    it.first_step = first;
    it.last_step  = last;
    return it;
  endfunction

  task automatic send_step(bgr_item_t it);
    if (burst_left == 0) burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
    in_push       <= 1'b1;
    in_activation <= it.activation;
    in_weight_0   <= it.weight[0];
    in_weight_1   <= it.weight[1];
    in_weight_2   <= it.weight[2];
    in_weight_3   <= it.weight[3];
    in_bias_0     <= it.bias[0];
    in_bias_1     <= it.bias[1];
    in_bias_2     <= it.bias[2];
    in_bias_3     <= it.bias[3];
    in_first_step <= it.first_step;
    in_last_step  <= it.last_step;
    do @(posedge clk); while (in_full);
    predict_step(it);
    burst_left--;
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_push    <= 1'b0;
    burst_left = 0;
    wait (tile_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_clamp(logic [2:0] addr, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == 3'(4 * REG_CLAMP_LOW)) clamp_lo = val;
    if (addr == 3'(4 * REG_CLAMP_HIGH)) clamp_hi = val;
  endtask

  task automatic set_bounds(logic [31:0] lo, logic [31:0] hi);
    wait_idle();
    write_clamp(3'(4 * REG_CLAMP_LOW), lo);
    write_clamp(3'(4 * REG_CLAMP_HIGH), hi);
  endtask

  // random dot products, mostly well formed with some stray flag patterns
  task automatic run_products(int n_steps);
    int sent, len;
    sent = 0;
    while (sent < n_steps) begin
      if ($urandom_range(0, 9) == 0) begin
        send_step(rand_item(1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        len = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 8);
        for (int k = 0; k < len; k++) send_step(rand_item(k == 0, k == len - 1));
        sent += len;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_special_cases();
    // first transaction after reset must load the biases
    send_step(make_item(16'h3F80, 16'h4000, 32'h3F80_0000, 1, 1));
    send_step(make_item(16'h0000, 16'hFFFF, 32'h0000_0000, 1, 1)); // NaN weight
    send_step(make_item(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1, 1));
    send_step(make_item(16'h7F80, 16'h0000, 32'h3F80_0000, 1, 1)); // inf * 0
    send_step(make_item(16'h7F80, 16'h3F80, 32'hFF80_0000, 1, 1)); // inf - inf
    send_step(make_item(16'hFF80, 16'h3F80, 32'hFF80_0000, 1, 1));
    send_step(make_item(16'h3F80, 16'h3F80, 32'hBF80_0000, 1, 1)); // exact cancel
    send_step(make_item(16'h8000, 16'h3F80, 32'h8000_0000, 1, 1)); // -0 + -0
    send_step(make_item(16'h0000, 16'h3F80, 32'h8000_0000, 1, 1));
    send_step(make_item(16'h7F7F, 16'h7F7F, 32'h7F7F_FFFF, 1, 1)); // overflow
    send_step(make_item(16'h0001, 16'h0001, 32'h0000_0001, 1, 1)); // subnormals
    send_step(make_item(16'h0080, 16'h0080, 32'h8000_0003, 1, 1));
    send_step(make_item(16'h3F80, 16'h3F80, 32'h7FFF_FFFF, 1, 1)); // NaN bias
    send_step(make_item(16'h3F81, 16'h3F81, 32'h3380_0000, 1, 1)); // bf16 rounding
    // multi-step sums with bias ignored on later steps
    send_step(make_item(16'h3F80, 16'h3F80, 32'h4000_0000, 1, 0));
    send_step(make_item(16'h4000, 16'h4040, 32'hFFFF_FFFF, 0, 0));
    send_step(make_item(16'hC000, 16'h3F80, 32'h7F80_0000, 0, 1));
    send_step(make_item(16'h4B80, 16'h3380, 32'h4B80_0000, 1, 0));
    send_step(make_item(16'h3380, 16'h3380, 32'h0, 0, 1));
    for (int k = 0; k < 4; k++) send_step(rand_item(1, 1));
  endtask

  task automatic test_clamp_settings();
    logic [31:0] los [7];
    logic [31:0] his [7];
    los = '{32'h7FC0_0000, 32'h8000_0000, 32'h3F80_0000, 32'h4000_0000,
            32'h0000_0000, 32'h0000_0001, CLAMP_LOW_RST};
    his = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h4000_0000, 32'h3F80_0000,
            32'hFFFF_FFFF, 32'h7F7F_FFFF, CLAMP_HIGH_RST};
    for (int s = 0; s < 7; s++) begin
      set_bounds(los[s], his[s]);
      send_step(make_item(16'h7FFF, 16'h3F80, 32'h0, 1, 1)); // NaN sum
      send_step(make_item(16'h8000, 16'h3F80, 32'h8000_0000, 1, 1));
      run_products(30);
    end
    set_bounds($urandom, $urandom);
    run_products(30);
    set_bounds(CLAMP_LOW_RST, CLAMP_HIGH_RST);
  endtask

  task automatic test_random_products();
    run_products(700);
  endtask

  task automatic test_backpressure();
    wait_idle();
    long_hold_req = 1'b1;
    burst_left = 1000;
    for (int k = 0; k < 40; k++) send_step(rand_item(1, $urandom_range(0, 2) != 0));
    long_hold_req = 1'b0;
    burst_left = 0;
    run_products(60);
  endtask

  // ---------------------------------------------------------------- checker
  int pop_mode;
  int hold_cycles;
  always @(posedge clk) begin
    bgr_result_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_out_3, out_out_2, out_out_1, out_out_0};
      if (tile_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tile %h", got);
      end else begin
        want = tile_q.pop_front();
        for (int i = 0; i < LANES; i++) begin
          if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("lane %0d: expected %h actual %h", i, want[i], got[i]);
          end
        end
      end
    end
    if (long_hold_req && hold_cycles == 0) hold_cycles <= 300;
    else if (hold_cycles > 1) hold_cycles <= hold_cycles - 1;
    if ($urandom_range(0, 31) == 0) pop_mode <= $urandom_range(0, 3);
    if (hold_cycles > 1 || (long_hold_req && hold_cycles == 0)) out_pop <= 1'b0;
    else case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= $urandom_range(0, 3) != 0;
      2: out_pop <= $urandom_range(0, 3) == 0;
      default: out_pop <= ~out_pop;
    endcase
  end

  // watchdog: no transaction on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bf16_gemm_row_clamp_narrow regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_activation = '0;
    {in_weight_0, in_weight_1, in_weight_2, in_weight_3} = '0;
    {in_bias_0, in_bias_1, in_bias_2, in_bias_3} = '0;
    in_first_step = 1'b0;
    in_last_step = 1'b0;
    out_pop = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    long_hold_req = 1'b0;
    pop_mode = 0;
    hold_cycles = 0;
    clamp_lo = CLAMP_LOW_RST;
    clamp_hi = CLAMP_HIGH_RST;
    for (int i = 0; i < LANES; i++) lane_acc[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_clamp_settings();
    test_random_products();
    test_backpressure();

    wait_idle();
    if (mismatches == 0)
      $display("bf16_gemm_row_clamp_narrow regression: pass");
    else
      $display("bf16_gemm_row_clamp_narrow regression: fail");
    $finish;
  end

endmodule
